// ===== rtl/core/mm_pkg.sv =====
package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = 6;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 72;

    localparam logic [1:0] OP_WRITE_LEFT  = 2'd0;
    localparam logic [1:0] OP_WRITE_RIGHT = 2'd1;
    localparam logic [1:0] OP_COMPUTE     = 2'd2;
    localparam logic [1:0] OP_NONE        = 2'd3;

    localparam logic [1:0] REG_LEFT_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [1:0] REG_RIGHT_COLS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // control token that walks down the cell chain with the operands
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             fin;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

// ===== rtl/core/mm_ram.sv =====
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/mm_mul_cell.sv =====
module mm_mul_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mm_pkg::tag_t                tag_in,
    input  logic signed [31:0]          a,
    input  logic signed [31:0]          b,
    output mm_pkg::tag_t                tag_out,
    output logic signed [mm_pkg::PROD_W-1:0] prod
);

    mm_pkg::tag_t                      tag_reg;
    logic signed [mm_pkg::PROD_W-1:0]  prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign tag_out = tag_reg;
    assign prod    = prod_reg;

endmodule

// ===== rtl/core/mm_acc_cell.sv =====
module mm_acc_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mm_pkg::tag_t                     tag_in,
    input  logic signed [mm_pkg::PROD_W-1:0] prod,
    output mm_pkg::tag_t                     tag_out,
    output logic signed [mm_pkg::ACC_W-1:0]  acc
);

    mm_pkg::tag_t                     tag_reg;
    logic signed [mm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mm_pkg::ACC_W-1:0]  acc_next;
    logic signed [mm_pkg::ACC_W-1:0]  prod_ext;

    assign prod_ext = mm_pkg::ACC_W'(prod);

    always_comb
    begin
        acc_next = acc_reg;
        if (tag_in.valid)
            acc_next = tag_in.first ? prod_ext : acc_reg + prod_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign tag_out = tag_reg;
    assign acc     = acc_reg;

endmodule

// ===== rtl/core/mm_sat_cell.sv =====
module mm_sat_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mm_pkg::tag_t                    tag_in,
    input  logic signed [mm_pkg::ACC_W-1:0] acc,
    output mm_pkg::tag_t                    tag_out,
    output logic [31:0]                     value,
    output logic                            sat
);

    localparam int SH_W = mm_pkg::ACC_W - mm_pkg::FRAC_BITS;

    mm_pkg::tag_t            tag_reg;
    logic [31:0]             value_reg;
    logic                    sat_reg;
    logic signed [mm_pkg::ACC_W-1:0] rnd;
    logic signed [SH_W-1:0]  sh;
    logic                    fits;

    always_comb
    begin
        if (mm_pkg::FRAC_BITS > 0)
            rnd = acc + (mm_pkg::ACC_W'(1) <<< (mm_pkg::FRAC_BITS - 1));
        else
            rnd = acc;
        sh   = SH_W'(rnd >>> mm_pkg::FRAC_BITS);
        fits = (sh[SH_W-1:31] == '0) || (sh[SH_W-1:31] == '1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= !fits;
        if (fits)
            value_reg <= sh[31:0];
        else
            value_reg <= sh[SH_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end

    assign tag_out = tag_reg;
    assign value   = value_reg;
    assign sat     = sat_reg;

endmodule

// ===== rtl/core/matrix_multiply_core.sv =====
// Q16.16 matrix multiply. Beats with operation (tuser) 0 or 1 write one
// element of the left or right store, one beat per cycle; operation 2 runs a
// compute that emits left_rows x right_cols result beats in row-major order,
// last set on the final one and the saturated flag in tuser. One
// multiply-accumulate chain (ram read, multiply, accumulate, round/saturate
// cells) takes one product term per cycle while the result fifo has
// free slots. A compute holds the input from the compute beat until the
// chain and fifo have drained and the last result beat has left, longer
// while the output stalls. Results are only defined for store entries
// written since reset.
module matrix_multiply_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row[2:0], col[5:3], value[37:6]
    input  logic [39:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_row[2:0], out_col[5:3], out_value[37:6]
    output logic [39:0] m_axis_tdata,
    // saturated[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata
);

    localparam int IW = mm_pkg::IDX_W;
    localparam int DW = mm_pkg::DIM_W;
    // result fifo depth covers the round trip from issue to fifo pop
    localparam int FD = 8;

    logic [DW-1:0] rows_reg, inner_reg, cols_reg;
    mm_pkg::state_t state_reg, state_next;
    logic [DW-1:0] r_reg, c_reg, k_reg;
    logic [DW-1:0] nr, nk, nc;

    logic [1:0]          op;
    logic [IW-1:0]       in_row, in_col;
    logic [31:0]         in_val;
    logic                in_acc;

    assign op     = s_axis_tuser;
    assign in_row = s_axis_tdata[2:0];
    assign in_col = s_axis_tdata[5:3];
    assign in_val = s_axis_tdata[37:6];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == mm_pkg::ST_IDLE);

    assign nr = mm_pkg::clamp_dim(rows_reg);
    assign nk = mm_pkg::clamp_dim(inner_reg);
    assign nc = mm_pkg::clamp_dim(cols_reg);

    // output holding register and result fifo
    logic        ovalid_reg;
    logic [38:0] odata_reg;
    logic        olast_reg;
    logic [38:0] fdata_reg [FD];
    logic        flast_reg [FD];
    logic [2:0]  fwp_reg, frp_reg;
    logic [3:0]  fcnt_reg;
    logic [3:0]  pend_reg;
    logic        fpush, fpop;
    logic        pipe_busy;

    mm_pkg::tag_t t0, t1, t2, t3, t4;
    logic issue;
    logic last_k, last_c, last_r;

    assign last_k = (k_reg == nk - DW'(1));
    assign last_c = (c_reg == nc - DW'(1));
    assign last_r = (r_reg == nr - DW'(1));

    assign issue = (state_reg == mm_pkg::ST_RUN) && !pipe_busy;

    always_comb
    begin
        t0.valid = issue;
        t0.first = (k_reg == '0);
        t0.fin   = last_k;
        t0.last  = last_k && last_c && last_r;
        t0.row   = r_reg[IW-1:0];
        t0.col   = c_reg[IW-1:0];
    end

    // every finished element issued holds a fifo slot until it is popped
    assign pipe_busy = (pend_reg == 4'(FD));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mm_pkg::ST_IDLE:
                if (in_acc && op == mm_pkg::OP_COMPUTE)
                    state_next = mm_pkg::ST_RUN;
            mm_pkg::ST_RUN:
                if (issue && t0.last)
                    state_next = mm_pkg::ST_DONE;
            mm_pkg::ST_DONE:
                if (!t1.valid && !t2.valid && !t3.valid && !t4.valid &&
                    fcnt_reg == '0 && !ovalid_reg)
                    state_next = mm_pkg::ST_IDLE;
            default:
                state_next = mm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm_pkg::ST_IDLE;
            rows_reg  <= DW'(4);
            inner_reg <= DW'(4);
            cols_reg  <= DW'(4);
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mm_pkg::REG_LEFT_ROWS:  rows_reg  <= cfg_wdata;
                    mm_pkg::REG_INNER_SIZE: inner_reg <= cfg_wdata;
                    mm_pkg::REG_RIGHT_COLS: cols_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_acc && op == mm_pkg::OP_COMPUTE)
            begin
                r_reg <= '0;
                c_reg <= '0;
                k_reg <= '0;
            end
            else if (issue)
            begin
                if (!last_k)
                    k_reg <= k_reg + DW'(1);
                else
                begin
                    k_reg <= '0;
                    if (!last_c)
                        c_reg <= c_reg + DW'(1);
                    else
                    begin
                        c_reg <= '0;
                        r_reg <= r_reg + DW'(1);
                    end
                end
            end
        end
    end

    // stores
    logic                      wl, wr;
    logic [mm_pkg::ADDR_W-1:0] waddr, laddr, raddr;
    logic [31:0]               ldata, rdata;

    assign wl    = in_acc && op == mm_pkg::OP_WRITE_LEFT;
    assign wr    = in_acc && op == mm_pkg::OP_WRITE_RIGHT;
    assign waddr = {in_row, in_col};
    assign laddr = {r_reg[IW-1:0], k_reg[IW-1:0]};
    assign raddr = {k_reg[IW-1:0], c_reg[IW-1:0]};

    mm_ram #(.WIDTH(32), .DEPTH(mm_pkg::DEPTH)) u_left (
        .clk(clk), .we(wl), .waddr(waddr), .wdata(in_val),
        .raddr(laddr), .rdata(ldata)
    );

    mm_ram #(.WIDTH(32), .DEPTH(mm_pkg::DEPTH)) u_right (
        .clk(clk), .we(wr), .waddr(waddr), .wdata(in_val),
        .raddr(raddr), .rdata(rdata)
    );

    // the chain advances every cycle; results wait in a small fifo at its end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t1 <= '0;
        else
            t1 <= t0;
    end

    logic signed [mm_pkg::PROD_W-1:0] prod;
    logic signed [mm_pkg::ACC_W-1:0]  acc;
    logic [31:0]                      sval;
    logic                             ssat;

    mm_mul_cell u_mul (
        .clk(clk), .rst_n(rst_n), .tag_in(t1), .a(ldata), .b(rdata),
        .tag_out(t2), .prod(prod)
    );

    mm_acc_cell u_acc (
        .clk(clk), .rst_n(rst_n), .tag_in(t2), .prod(prod),
        .tag_out(t3), .acc(acc)
    );

    mm_pkg::tag_t t3f;
    always_comb
    begin
        t3f = t3;
        t3f.valid = t3.valid && t3.fin;
    end

    mm_sat_cell u_sat (
        .clk(clk), .rst_n(rst_n), .tag_in(t3f), .acc(acc),
        .tag_out(t4), .value(sval), .sat(ssat)
    );

    assign fpush = t4.valid;
    assign fpop  = (fcnt_reg != '0) && (!ovalid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwp_reg    <= '0;
            frp_reg    <= '0;
            fcnt_reg   <= '0;
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (fpush)
                fwp_reg <= fwp_reg + 3'd1;
            if (fpop)
                frp_reg <= frp_reg + 3'd1;
            fcnt_reg <= fcnt_reg + 4'(fpush) - 4'(fpop);
            pend_reg <= pend_reg + 4'(issue && t0.fin) - 4'(fpop);
            if (fpop)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fpush)
        begin
            fdata_reg[fwp_reg] <= {ssat, sval, t4.col, t4.row};
            flast_reg[fwp_reg] <= t4.last;
        end
        if (fpop)
        begin
            odata_reg <= fdata_reg[frp_reg];
            olast_reg <= flast_reg[frp_reg];
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, odata_reg[37:0]};
    assign m_axis_tuser  = odata_reg[38];
    assign m_axis_tlast  = olast_reg;

    logic unused_ok;
    assign unused_ok = ^s_axis_tdata[39:38];

`ifndef SYNTHESIS
    a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != mm_pkg::ST_IDLE |-> !s_axis_tready)
        else $error("input accepted during compute");
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= 4'(FD))
        else $error("result fifo overflow");
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 4'(FD))
        else $error("more elements in flight than fifo slots");
    a_issue_run: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> state_reg == mm_pkg::ST_RUN)
        else $error("issue outside compute");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
`endif

endmodule
